// ===== rtl/pdt_pkg.sv =====
// Package for the prescaled down timer: request codes, status bit positions,
// widths and the tone tap function. No dependencies.
package pdt_pkg;

	// Counter width (valid range 11 to 16; tone taps reach bit 10)
	localparam int CntW  = 12;
	localparam int DataW = 16;
	localparam int ReqW  = 3;
	localparam int PscW  = 4;
	localparam int TonW  = 6;

	// Request codes
	localparam logic [ReqW-1:0] ReqTick      = 3'd0;
	localparam logic [ReqW-1:0] ReqRdValue   = 3'd1;
	localparam logic [ReqW-1:0] ReqRdReload  = 3'd2;
	localparam logic [ReqW-1:0] ReqRdStatus  = 3'd3;
	localparam logic [ReqW-1:0] ReqWrReload  = 3'd4;
	localparam logic [ReqW-1:0] ReqWrControl = 3'd5;
	localparam logic [ReqW-1:0] ReqWrTones   = 3'd6;

	// Control and status bit positions
	localparam int StEnable   = 0;
	localparam int StOverflow = 3;
	localparam int StExternal = 5;
	localparam int StZero     = 7;

	// Bits a control write leaves untouched
	localparam logic [DataW-1:0] StKeep = 16'o250;

	// Tone enable layout: bits 0..4 gate taps, bit 5 is master enable
	localparam int TonMaster = 5;

	typedef logic [CntW-1:0] cnt_t;

	// Tone level from counter taps gated by the enables
	function automatic logic tone_level(input cnt_t cnt, input logic mute,
			input logic [TonW-1:0] en);
		logic [4:0] taps;
		taps = {cnt[10], cnt[8], cnt[7], cnt[6], cnt[3] & ~mute};
		return en[TonMaster] && ((taps & en[4:0]) == 5'd0);
	endfunction

endpackage

// ===== rtl/prescaled_down_timer_with_tones.sv =====
// Prescaled 12-bit down timer with tone output, as one request stream.
// Depends on pdt_pkg.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready| s_tuser: req_type; s_tdata: write_data
//  m_*     | out | m_tvalid/m_tready| m_tdata: read_data, sound_level, zeros
//
// Each request passes through the input register, then through the update logic
// into the result register.
// A new request is accepted every cycle as long as results are taken.
// arst_n clears all timer state and both valid flags at once.
// A stalled result holds the input register; s_tready drops only when both
// the input register and the result register are full.
module prescaled_down_timer_with_tones (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [pdt_pkg::DataW-1:0] s_tdata,   // [15:0] write_data
	input  logic [pdt_pkg::ReqW-1:0]  s_tuser,   // [2:0] req_type
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata    // [15:0] read_data, [16] sound_level
);

	logic                      vld_s1;
	logic [pdt_pkg::ReqW-1:0]  req_s1;
	logic [pdt_pkg::DataW-1:0] data_s1;
	logic                      vld_s2;
	logic [pdt_pkg::DataW-1:0] rd_s2;
	logic                      snd_s2;

	pdt_pkg::cnt_t             cnt_q, cnt_d, rld_q, rld_d, cnt_dec;
	logic [pdt_pkg::DataW-1:0] ctl_q, ctl_d;
	logic [pdt_pkg::PscW-1:0]  psc_q, psc_d, psc_inc, divisor;
	logic                      mute_q, mute_d;
	logic [pdt_pkg::TonW-1:0]  ten_q, ten_d;
	logic [pdt_pkg::DataW-1:0] rd;
	logic                      adv;
	logic                      step;

	// Advance the pipe when the result register is free or being drained
	assign adv      = !vld_s2 || m_tready;
	assign step     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	// Update logic for one request
	always_comb begin
		cnt_d   = cnt_q;
		rld_d   = rld_q;
		ctl_d   = ctl_q;
		psc_d   = psc_q;
		mute_d  = mute_q;
		ten_d   = ten_q;
		rd      = '0;
		psc_inc = psc_q + 1'b1;
		cnt_dec = cnt_q - 1'b1;
		divisor = pdt_pkg::PscW'(1) << ctl_q[2:1];
		case (req_s1)
			pdt_pkg::ReqTick: begin
				if (ctl_q[pdt_pkg::StEnable]) begin
					if (psc_inc < divisor) begin
						psc_d = psc_inc;
					end else begin
						psc_d = '0;
						cnt_d = cnt_dec;
						if (cnt_dec == '0) begin
							cnt_d = rld_q;
							ctl_d[pdt_pkg::StZero] = 1'b1;
							if (ctl_q[pdt_pkg::StZero])
								ctl_d[pdt_pkg::StOverflow] = 1'b1;
						end
					end
				end
			end
			pdt_pkg::ReqRdValue: begin
				rd = pdt_pkg::DataW'(cnt_q);
				ctl_d[pdt_pkg::StZero] = 1'b0;
			end
			pdt_pkg::ReqRdReload: begin
				rd = pdt_pkg::DataW'(rld_q);
			end
			pdt_pkg::ReqRdStatus: begin
				rd = ctl_q;
				ctl_d[pdt_pkg::StOverflow] = 1'b0;
				ctl_d[pdt_pkg::StExternal] = 1'b0;
			end
			pdt_pkg::ReqWrReload: begin
				rld_d = data_s1[pdt_pkg::CntW-1:0];
				if (!ctl_q[pdt_pkg::StEnable])
					cnt_d = data_s1[pdt_pkg::CntW-1:0];
			end
			pdt_pkg::ReqWrControl: begin
				if (data_s1[pdt_pkg::StEnable] && !ctl_q[pdt_pkg::StEnable])
					cnt_d = rld_q;
				ctl_d  = (ctl_q & pdt_pkg::StKeep) | (data_s1 & ~pdt_pkg::StKeep);
				mute_d = !data_s1[2];
			end
			pdt_pkg::ReqWrTones: begin
				ten_d = {data_s1[7], data_s1[8], data_s1[9], data_s1[10], data_s1[11],
					data_s1[12]};
			end
			default: begin
			end
		endcase
	end

	// Timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rld_q  <= '0;
			ctl_q  <= '0;
			psc_q  <= '0;
			mute_q <= 1'b0;
			ten_q  <= '0;
		end else if (step) begin
			cnt_q  <= cnt_d;
			rld_q  <= rld_d;
			ctl_q  <= ctl_d;
			psc_q  <= psc_d;
			mute_q <= mute_d;
			ten_q  <= ten_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rd_s2  <= rd;
			snd_s2 <= pdt_pkg::tone_level(cnt_d, mute_d, ten_d);
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {7'd0, snd_s2, rd_s2};

endmodule

// ===== rtl/pdt_checker.sv =====
// Port-level checker for the prescaled down timer, with its bind.
// Depends on prescaled_down_timer_with_tones, the target of the bind.
module pdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic [1:0] pend_q;
	logic       acc_in;
	logic       acc_out;

	assign acc_in  = s_tvalid && s_tready;
	assign acc_out = m_tvalid && m_tready;

	// Track requests accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, acc_in} - {1'b0, acc_out};
		end
	end

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// No more than two requests in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("too many requests in flight");

	// A result only for a pending request
	a_noinvent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without request");

	// Empty pipe always takes a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> s_tready)
		else $error("empty block not ready");

	// Padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0)
		else $error("result padding not zero");

endmodule

bind prescaled_down_timer_with_tones pdt_checker u_pdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for prescaled_down_timer_with_tones: streams ticks and
// bus accesses, predicts every result with a behavioral timer and checks in order.
// Depends on pdt_pkg and the timer RTL.
module tb_top;

	localparam logic [pdt_pkg::ReqW-1:0] ReqUnused = 3'd7;
	localparam int RateLsb     = 1;
	localparam int RandomItems = 700;
	localparam int HoldCycles  = 60;
	localparam int CycleLimit  = 200000;

	typedef struct {
		logic                      wait_drain;
		logic [pdt_pkg::ReqW-1:0]  req;
		logic [pdt_pkg::DataW-1:0] data;
	} timer_req_t;

	typedef struct {
		logic [pdt_pkg::DataW-1:0] read_data;
		logic                      sound;
	} timer_rsp_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [pdt_pkg::DataW-1:0] s_tdata  = '0;   // [15:0] write_data
	logic [pdt_pkg::ReqW-1:0]  s_tuser  = '0;   // [2:0] req_type
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [23:0]               m_tdata;         // [15:0] read_data, [16] sound_level, zeros

	timer_req_t pending_reqs[$];
	timer_rsp_t expected_rsps[$];
	int n_queued   = 0;
	int n_issued   = 0;
	int n_accepted = 0;
	int n_errors   = 0;
	int cycle_cnt  = 0;
	int hold_left  = 0;
	int holds_done = 0;
	int idle_phase = 0;
	int send_idle_pct[3] = '{22, 84, 0};
	int recv_idle_pct[3] = '{84, 22, 0};

	// Behavioral timer state
	logic [pdt_pkg::CntW-1:0]  tmr_count  = '0;
	logic [pdt_pkg::CntW-1:0]  tmr_reload = '0;
	logic [pdt_pkg::DataW-1:0] tmr_ctrl   = '0;
	logic [pdt_pkg::PscW-1:0]  tmr_psc    = '0;
	logic                      tmr_mute   = 1'b0;
	logic [pdt_pkg::TonW-1:0]  tmr_tones  = '0;

	prescaled_down_timer_with_tones u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Apply one request to the timer state and compute its result
	task automatic timer_apply(input logic [pdt_pkg::ReqW-1:0] req,
			input logic [pdt_pkg::DataW-1:0] data, output timer_rsp_t rsp);
		logic [4:0]               taps;
		logic [pdt_pkg::PscW-1:0] divisor;
		rsp.read_data = '0;
		case (req)
			pdt_pkg::ReqTick: begin
				if (tmr_ctrl[pdt_pkg::StEnable]) begin
					divisor = 4'd1 << tmr_ctrl[RateLsb +: 2];
					tmr_psc = tmr_psc + 1'b1;
					if (tmr_psc >= divisor) begin
						tmr_psc   = '0;
						tmr_count = tmr_count - 1'b1;
						// wrap: reload, flag zero, flag overflow on a missed zero
						if (tmr_count == '0) begin
							if (tmr_ctrl[pdt_pkg::StZero])
								tmr_ctrl[pdt_pkg::StOverflow] = 1'b1;
							tmr_ctrl[pdt_pkg::StZero] = 1'b1;
							tmr_count = tmr_reload;
						end
					end
				end
			end
			pdt_pkg::ReqRdValue: begin
				rsp.read_data = pdt_pkg::DataW'(tmr_count);
				tmr_ctrl[pdt_pkg::StZero] = 1'b0;
			end
			pdt_pkg::ReqRdReload: begin
				rsp.read_data = pdt_pkg::DataW'(tmr_reload);
			end
			pdt_pkg::ReqRdStatus: begin
				rsp.read_data = tmr_ctrl;
				tmr_ctrl[pdt_pkg::StOverflow] = 1'b0;
				tmr_ctrl[pdt_pkg::StExternal] = 1'b0;
			end
			pdt_pkg::ReqWrReload: begin
				tmr_reload = data[pdt_pkg::CntW-1:0];
				if (!tmr_ctrl[pdt_pkg::StEnable])
					tmr_count = tmr_reload;
			end
			pdt_pkg::ReqWrControl: begin
				if (data[pdt_pkg::StEnable] && !tmr_ctrl[pdt_pkg::StEnable])
					tmr_count = tmr_reload;
				tmr_ctrl = (tmr_ctrl & pdt_pkg::StKeep) | (data & ~pdt_pkg::StKeep);
				tmr_mute = (tmr_ctrl[RateLsb +: 2] <= 2'd1);
			end
			pdt_pkg::ReqWrTones: begin
				tmr_tones = {data[7], data[8], data[9], data[10], data[11], data[12]};
			end
			default: begin
			end
		endcase
		taps = {tmr_count[10], tmr_count[8], tmr_count[7], tmr_count[6],
			tmr_count[3] & ~tmr_mute};
		rsp.sound = tmr_tones[pdt_pkg::TonMaster] && ((taps & tmr_tones[4:0]) == 5'd0);
	endtask

	task automatic push_req(input logic [pdt_pkg::ReqW-1:0] req,
			input logic [pdt_pkg::DataW-1:0] data);
		timer_req_t item;
		item.wait_drain = 1'b0;
		item.req        = req;
		item.data       = data;
		pending_reqs.push_back(item);
		n_queued++;
	endtask

	task automatic push_drain();
		timer_req_t item;
		item.wait_drain = 1'b1;
		item.req        = pdt_pkg::ReqTick;
		item.data       = '0;
		pending_reqs.push_back(item);
	endtask

	// One well-formed run: load, start, then ticks mixed with reads and rewrites
	task automatic push_timer_run();
		logic [pdt_pkg::DataW-1:0] wd;
		int n_ticks;
		int pick;
		if ($urandom_range(3) == 0) begin
			wd = pdt_pkg::DataW'($urandom);
			wd[pdt_pkg::StEnable] = 1'b0;
			push_req(pdt_pkg::ReqWrControl, wd);
		end
		wd = pdt_pkg::DataW'($urandom);
		if ($urandom_range(4) != 0)
			wd[pdt_pkg::CntW-1:0] = pdt_pkg::CntW'($urandom_range(8, 1));
		push_req(pdt_pkg::ReqWrReload, wd);
		wd = pdt_pkg::DataW'($urandom);
		wd[pdt_pkg::StEnable] = 1'b1;
		wd[RateLsb +: 2] = 2'(($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(1));
		push_req(pdt_pkg::ReqWrControl, wd);
		if ($urandom_range(1) == 0)
			push_req(pdt_pkg::ReqWrTones, pdt_pkg::DataW'($urandom));
		n_ticks = $urandom_range(48, 8);
		for (int i = 0; i < n_ticks; i++) begin
			pick = $urandom_range(19);
			if (pick < 4) begin
				push_req(pdt_pkg::ReqW'($urandom_range(pdt_pkg::ReqRdStatus,
					pdt_pkg::ReqRdValue)), pdt_pkg::DataW'($urandom));
			end else if (pick == 4) begin
				wd = pdt_pkg::DataW'($urandom);
				wd[pdt_pkg::StEnable] = 1'b1;
				push_req(pdt_pkg::ReqWrControl, wd);
			end else if (pick == 5) begin
				push_req(pdt_pkg::ReqWrReload, pdt_pkg::DataW'($urandom_range(15, 1)));
			end else begin
				push_req(pdt_pkg::ReqTick, pdt_pkg::DataW'($urandom));
			end
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		int first_random;
		int n_noise;
		push_req(pdt_pkg::ReqRdStatus, 16'hFFFF);     // idle timer reads back zeros
		push_req(pdt_pkg::ReqRdValue, 16'h0000);
		push_req(pdt_pkg::ReqWrTones, 16'hFFFF);      // every tap and the master enable
		push_req(pdt_pkg::ReqWrReload, 16'hFFFF);     // stopped: counter loads as well
		push_req(pdt_pkg::ReqRdValue, 16'hFFFF);
		push_req(pdt_pkg::ReqRdReload, 16'h0000);
		push_req(pdt_pkg::ReqTick, 16'hFFFF);         // stopped timer ignores ticks
		push_req(ReqUnused, 16'hFFFF);                // unused code changes nothing
		push_req(pdt_pkg::ReqWrReload, 16'h0002);
		push_req(pdt_pkg::ReqWrControl, 16'h0001);    // start at full rate, counter loads
		repeat (4) push_req(pdt_pkg::ReqTick, 16'h0000);  // zero, then overflow on second wrap
		push_req(pdt_pkg::ReqRdStatus, 16'h0000);
		push_req(pdt_pkg::ReqRdStatus, 16'h0000);     // overflow now clear
		push_req(pdt_pkg::ReqRdValue, 16'h0000);      // clears zero
		push_req(pdt_pkg::ReqWrControl, 16'hFFFF);    // slowest rate, kept bits untouched
		push_drain();
		repeat (3) push_req(pdt_pkg::ReqTick, 16'h0000);
		push_req(pdt_pkg::ReqWrControl, 16'h0003);    // faster rate mid-count expires at once
		push_req(pdt_pkg::ReqTick, 16'h0000);
		push_req(pdt_pkg::ReqRdValue, 16'h0000);
		push_req(pdt_pkg::ReqWrControl, 16'h0000);
		push_req(pdt_pkg::ReqWrTones, 16'h0000);
		push_req(pdt_pkg::ReqRdStatus, 16'h0000);

		first_random = n_queued;
		while (n_queued - first_random < RandomItems) begin
			case ($urandom_range(9))
				7, 8: begin
					n_noise = $urandom_range(6, 1);
					repeat (n_noise)
						push_req(pdt_pkg::ReqW'($urandom_range(7)), pdt_pkg::DataW'($urandom));
				end
				9: begin
					push_drain();
					push_req(pdt_pkg::ReqW'($urandom_range(7)), pdt_pkg::DataW'($urandom));
				end
				default: push_timer_run();
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (n_accepted < n_queued || expected_rsps.size() != 0);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// Bound the run
	initial begin
		while (cycle_cnt < CycleLimit) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// Request driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk) begin
		timer_rsp_t rsp;
		timer_req_t head;
		logic       offer;
		if (arst_n) begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				timer_apply(s_tuser, s_tdata, rsp);
				expected_rsps.push_back(rsp);
				n_accepted++;
				offer = 1'b0;
			end
			idle_phase = (n_issued * 3) / n_queued;
			if (idle_phase > 2)
				idle_phase = 2;
			if (!offer && pending_reqs.size() != 0) begin
				if (pending_reqs[0].wait_drain) begin
					// hold off until every result is back
					if (expected_rsps.size() == 0)
						void'(pending_reqs.pop_front());
				end else if ($urandom_range(99) >= send_idle_pct[idle_phase]) begin
					head = pending_reqs.pop_front();
					s_tuser <= head.req;
					s_tdata <= head.data;
					n_issued++;
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Result ready: random stalls plus two long hold-offs to back up the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if ((holds_done == 0 && n_issued >= 100) ||
					(holds_done == 1 && n_issued >= n_queued * 2 / 3 + 50)) begin
				hold_left  <= HoldCycles;
				holds_done <= holds_done + 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
			end
		end
	end

	// Result monitor: compare against the oldest expected result
	always @(posedge clk) begin
		timer_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rsps.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result: tdata=%h", m_tdata);
			end else begin
				want = expected_rsps.pop_front();
				if (m_tdata[pdt_pkg::DataW-1:0] !== want.read_data ||
						m_tdata[pdt_pkg::DataW] !== want.sound ||
						m_tdata[23:pdt_pkg::DataW+1] !== '0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: read_data exp %h got %h, sound exp %b got %b, pad %h",
							want.read_data, m_tdata[pdt_pkg::DataW-1:0], want.sound,
							m_tdata[pdt_pkg::DataW], m_tdata[23:pdt_pkg::DataW+1]);
				end
			end
		end
	end

endmodule

// ===== prescaled_down_timer_with_tones.f =====
rtl/pdt_pkg.sv
rtl/prescaled_down_timer_with_tones.sv
rtl/pdt_checker.sv
dv/tb_top.sv
